// ----- sv/lcdseq_pkg.sv -----
// ============================================================================
// lcdseq_pkg
// Types, constants and transfer tables shared by the character display
// nibble sequencer.
// ============================================================================
package lcdseq_pkg;

  // Request kinds as they arrive on the command field.
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Display instruction and data bytes.
  localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] ROW1_OFFSET    = 8'h40;
  localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
  localparam logic [7:0] FAIL_ADDR      = 8'h86;
  localparam logic [7:0] ROW1_START     = 8'hC0;
  localparam logic [3:0] WAKE_NIBBLE    = 4'h3;
  localparam logic [3:0] FOUR_BIT_NIB   = 4'h2;

  // Power-up waits in microseconds.
  localparam logic [13:0] WAIT_POWER_ON = 14'd15000;
  localparam logic [13:0] WAIT_SECOND   = 14'd4100;
  localparam logic [13:0] WAIT_THIRD    = 14'd100;

  // Last step index of each sequence.
  localparam logic [3:0] LAST_INIT  = 4'd13;
  localparam logic [3:0] LAST_CLEAR = 4'd1;
  localparam logic [3:0] LAST_WRITE = 4'd3;
  localparam logic [3:0] LAST_FAIL  = 4'd11;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_CLEAR,
    KIND_WRITE,
    KIND_FAIL
  } kind_t;

  typedef logic [3:0] step_t;

  // Request transaction payload.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [1:0] row;
    logic [4:0] column;
  } req_t;

  // Bus transfer transaction payload.
  typedef struct packed {
    logic [3:0]  nibble;
    logic        reg_select;
    logic [13:0] wait_us;
    logic        last;
  } xfer_t;

  // Classified request held in the queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] addr;
    logic [7:0] char_code;
  } desc_t;

  // Sequencer status seen by the top level.
  typedef struct packed {
    logic  active;
    step_t step;
  } back_status_t;

  // Bytes of the init sequence after the wake-up nibbles.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h28;
      3'd1:    b = 8'h08;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      default: b = 8'h01;
    endcase
    return b;
  endfunction

  // Characters of the error text.
  function automatic logic [7:0] fail_char(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h46;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h49;
      default: b = 8'h4C;
    endcase
    return b;
  endfunction

  function automatic step_t last_step(input kind_t kind);
    step_t s;
    case (kind)
      KIND_INIT:  s = LAST_INIT;
      KIND_CLEAR: s = LAST_CLEAR;
      KIND_WRITE: s = LAST_WRITE;
      default:    s = LAST_FAIL;
    endcase
    return s;
  endfunction

  // One transfer of a classified request at a given step. Whole bytes
  // always start on an even step, so step bit 0 picks the low nibble.
  function automatic xfer_t step_xfer(input desc_t d, input step_t step);
    logic [7:0]  b;
    logic        rs;
    logic        lo_only;
    logic [13:0] w;
    step_t       rel;
    xfer_t       x;
    b       = 8'h00;
    rs      = 1'b0;
    lo_only = 1'b0;
    w       = 14'd0;
    rel     = 4'd0;
    case (d.kind)
      KIND_INIT: begin
        if (step < 4'd4) begin
          lo_only = 1'b1;
          b       = {4'h0, (step == 4'd3) ? FOUR_BIT_NIB : WAKE_NIBBLE};
          case (step)
            4'd0:    w = WAIT_POWER_ON;
            4'd1:    w = WAIT_SECOND;
            4'd2:    w = WAIT_THIRD;
            default: w = 14'd0;
          endcase
        end else begin
          rel = step - 4'd4;
          b   = init_byte(rel[3:1]);
        end
      end
      KIND_CLEAR: b = CLEAR_DISPLAY;
      KIND_WRITE: begin
        rs = step[1];
        b  = step[1] ? d.char_code : d.addr;
      end
      default: begin
        if (step < 4'd2) begin
          b = FAIL_ADDR;
        end else if (step < 4'd10) begin
          rel = step - 4'd2;
          rs  = 1'b1;
          b   = fail_char(rel[2:1]);
        end else begin
          b = ROW1_START;
        end
      end
    endcase
    x.nibble     = (lo_only || step[0]) ? b[3:0] : b[7:4];
    x.reg_select = rs;
    x.wait_us    = w;
    x.last       = (step == last_step(d.kind));
    return x;
  endfunction

endpackage

// ----- sv/lcdseq_front.sv -----
// ============================================================================
// lcdseq_front
// Accepts requests, drops those that produce no transfer and classifies the
// rest into queue entries with the address byte already formed.
// ============================================================================
module lcdseq_front (
  input  logic                start,
  input  logic                full,
  input  lcdseq_pkg::req_t    req,
  output logic                busy,
  output logic                push,
  output lcdseq_pkg::desc_t   desc
);

  logic accept;
  logic has_output;

  // The front stalls only on a full queue.
  assign busy   = full;
  assign accept = start && !full;

  // Classification and address formation.
  always_comb begin
    has_output     = 1'b0;
    desc.kind      = lcdseq_pkg::KIND_CLEAR;
    desc.char_code = req.char_code;
    desc.addr      = lcdseq_pkg::SET_DDRAM_ADDR
                   | (req.row[0] ? lcdseq_pkg::ROW1_OFFSET : 8'h00)
                   | {4'h0, req.column[3:0]};
    case (req.cmd)
      lcdseq_pkg::CMD_INIT: begin
        has_output = 1'b1;
        desc.kind  = lcdseq_pkg::KIND_INIT;
      end
      lcdseq_pkg::CMD_CLEAR: begin
        has_output = 1'b1;
        desc.kind  = lcdseq_pkg::KIND_CLEAR;
      end
      lcdseq_pkg::CMD_WRITE: begin
        if (req.row > 2'd1) begin
          has_output = 1'b1;
          desc.kind  = lcdseq_pkg::KIND_FAIL;
        end else begin
          has_output = !req.column[4];
          desc.kind  = lcdseq_pkg::KIND_WRITE;
        end
      end
      default: has_output = 1'b0;
    endcase
  end

  assign push = accept && has_output;

endmodule

// ----- sv/lcdseq_queue.sv -----
// ============================================================================
// lcdseq_queue
// Small FIFO of classified requests between the front and the sequencer.
// ============================================================================
module lcdseq_queue #(
  parameter int QDepth = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lcdseq_pkg::desc_t  push_data,
  input  logic               pop,
  output lcdseq_pkg::desc_t  head,
  output logic               empty,
  output logic               full
);

  localparam int IW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CW = $clog2(QDepth + 1);

  lcdseq_pkg::desc_t entries [QDepth];
  logic [IW-1:0]     wr_ptr;
  logic [IW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(QDepth));
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(QDepth - 1)) ? '0 : wr_ptr + IW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(QDepth - 1)) ? '0 : rd_ptr + IW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- sv/lcdseq_back.sv -----
// ============================================================================
// lcdseq_back
// Steps through the transfers of one queued request per cycle and drives the
// registered transfer strobe and payload.
// ============================================================================
module lcdseq_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lcdseq_pkg::desc_t        head,
  input  logic                     empty,
  output logic                     pop,
  output logic                     strobe,
  output lcdseq_pkg::xfer_t        xfer,
  output lcdseq_pkg::back_status_t status
);

  lcdseq_pkg::desc_t cur;
  lcdseq_pkg::step_t step;
  logic              active;
  logic              finishing;

  // Load the next request on the cycle the current one ends.
  assign finishing = active && (step == lcdseq_pkg::last_step(cur.kind));
  assign pop       = !empty && (!active || finishing);

  assign status.active = active;
  assign status.step   = step;

  // Sequencer state and registered transfer output.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
      step   <= '0;
    end else begin
      strobe <= active;
      if (active) begin
        step <= step + 4'd1;
      end
      if (finishing) begin
        active <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
        step   <= '0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (active) begin
      xfer <= lcdseq_pkg::step_xfer(cur, step);
    end
    if (pop) begin
      cur <= head;
    end
  end

endmodule

// ----- sv/char_lcd_nibble_sequencer.sv -----
// ============================================================================
// char_lcd_nibble_sequencer
// Expands character display requests into 4-bit bus transfers.
// ============================================================================
// When the sequencer is idle, a taken request passes through the queue and the
// sequencer's request register before its registered first transfer strobes.
// Throughput: one transfer per cycle; a request expands into 14 (init),
// 2 (clear), 4 (write) or 12 (bad row) transfers; one with no transfers is
// dropped at the front. Busy rises while the queue is full.
// Reset clears the queue and the sequencer at once; the receiver cannot stall.
module char_lcd_nibble_sequencer #(
  parameter int QDepth = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lcdseq_pkg::req_t  req,
  output logic              strobe,
  output lcdseq_pkg::xfer_t xfer
);

  logic                     full;
  logic                     empty;
  logic                     push;
  logic                     pop;
  lcdseq_pkg::desc_t        push_desc;
  lcdseq_pkg::desc_t        head;
  lcdseq_pkg::back_status_t bk_status;

  // Request classification.
  lcdseq_front u_front (
    .start (start),
    .full  (full),
    .req   (req),
    .busy  (busy),
    .push  (push),
    .desc  (push_desc)
  );

  // Queue between classification and sequencing.
  lcdseq_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Transfer sequencer.
  lcdseq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .strobe (strobe),
    .xfer   (xfer),
    .status (bk_status)
  );

  // A strobe follows a cycle in which the sequencer was working.
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(bk_status.active))
    else $error("transfer strobe without an active sequence");

  // Transfers of one request leave back to back.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && !xfer.last) |=> strobe)
    else $error("gap inside a transfer sequence");

  // The front never writes into a full queue.
  assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into a full queue");

  // The sequencer never reads from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from an empty queue");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for char_lcd_nibble_sequencer
// Sends display requests through the start/busy command handshake. Each
// request is expanded locally into the 4-bit transfers the display should
// see, and every strobed transfer is compared with the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // Request kind with no sequence behind it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Byte tables for power-up and the bad-row message.
  localparam logic [39:0] POWER_UP_BYTES = 40'h28_08_0C_06_01;
  localparam logic [31:0] ERROR_TEXT     = 32'h46_41_49_4C;

  localparam int STALL_LIMIT = 2000;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  lcdseq_pkg::req_t   req_in = '0;
  logic               strobe;
  lcdseq_pkg::xfer_t  xfer;

  lcdseq_pkg::xfer_t pending_xfers[$];
  int    error_count = 0;
  int    requests_sent = 0;
  int    xfers_checked = 0;
  int    stall_cycles = 0;

  char_lcd_nibble_sequencer dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req_in),
    .strobe(strobe),
    .xfer  (xfer)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Expected transfer builders.
  function automatic void push_xfer(logic [3:0] nib, logic rs,
                                    logic [13:0] wait_time);
    lcdseq_pkg::xfer_t x;
    x.nibble     = nib;
    x.reg_select = rs;
    x.wait_us    = wait_time;
    x.last       = 1'b0;
    pending_xfers.push_back(x);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic rs);
    push_xfer(b[7:4], rs, 14'd0);
    push_xfer(b[3:0], rs, 14'd0);
  endfunction

  // Expands one request into the transfers the display should receive.
  function automatic void expand_request(lcdseq_pkg::req_t r);
    int                before_len;
    lcdseq_pkg::xfer_t tail;
    before_len = pending_xfers.size();
    case (r.cmd)
      lcdseq_pkg::CMD_INIT: begin
        push_xfer(lcdseq_pkg::WAKE_NIBBLE, 1'b0, lcdseq_pkg::WAIT_POWER_ON);
        push_xfer(lcdseq_pkg::WAKE_NIBBLE, 1'b0, lcdseq_pkg::WAIT_SECOND);
        push_xfer(lcdseq_pkg::WAKE_NIBBLE, 1'b0, lcdseq_pkg::WAIT_THIRD);
        push_xfer(lcdseq_pkg::FOUR_BIT_NIB, 1'b0, 14'd0);
        for (int i = 0; i < 5; i++) begin
          push_byte(POWER_UP_BYTES[39 - 8 * i -: 8], 1'b0);
        end
      end
      lcdseq_pkg::CMD_CLEAR: push_byte(lcdseq_pkg::CLEAR_DISPLAY, 1'b0);
      lcdseq_pkg::CMD_WRITE: begin
        if (r.row <= 2'd1) begin
          if (r.column <= 5'd15) begin
            push_byte(lcdseq_pkg::SET_DDRAM_ADDR + {3'd0, r.column}
                      + (r.row[0] ? lcdseq_pkg::ROW1_OFFSET : 8'h00),
                      1'b0);
            push_byte(r.char_code, 1'b1);
          end
        end else begin
          // Bad row: the error text goes to the top line, then the cursor moves to the start of row 1.
          push_byte(lcdseq_pkg::FAIL_ADDR, 1'b0);
          for (int i = 0; i < 4; i++) begin
            push_byte(ERROR_TEXT[31 - 8 * i -: 8], 1'b1);
          end
          push_byte(lcdseq_pkg::ROW1_START, 1'b0);
        end
      end
      default: ;
    endcase
    if (pending_xfers.size() > before_len) begin
      tail = pending_xfers.pop_back();
      tail.last = 1'b1;
      pending_xfers.push_back(tail);
    end
  endfunction

  // Presents one request and holds it until the sequencer takes it.
  task automatic send_req(lcdseq_pkg::req_t r);
    @(negedge clk);
    start  <= 1'b1;
    req_in <= r;
    do begin
      @(posedge clk);
    end while (busy);
    expand_request(r);
    requests_sent++;
  endtask

  task automatic pause_sender(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Holds off the sender until every expected transfer has come out.
  task automatic drain_outputs();
    pause_sender(1);
    while (pending_xfers.size() != 0) begin
      @(negedge clk);
    end
    pause_sender(4);
  endtask

  function automatic lcdseq_pkg::req_t make_req(logic [1:0] cmd, logic [7:0] ch,
                                                logic [1:0] row, logic [4:0] col);
    lcdseq_pkg::req_t r;
    r.cmd       = cmd;
    r.char_code = ch;
    r.row       = row;
    r.column    = col;
    return r;
  endfunction

  // Directed tests.
  task automatic test_init_and_clear();
    send_req(make_req(lcdseq_pkg::CMD_INIT, 8'hFF, 2'd3, 5'd31));
    send_req(make_req(lcdseq_pkg::CMD_CLEAR, 8'h00, 2'd0, 5'd0));
    send_req(make_req(lcdseq_pkg::CMD_CLEAR, 8'hFF, 2'd3, 5'd31));
    send_req(make_req(lcdseq_pkg::CMD_INIT, 8'h00, 2'd0, 5'd0));
    drain_outputs();
  endtask

  task automatic test_write_corners();
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h00, 2'd0, 5'd0));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'hFF, 2'd1, 5'd15));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'hA5, 2'd0, 5'd15));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h5A, 2'd1, 5'd0));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h41, 2'd1, 5'd10));
    pause_sender(3);
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h7E, 2'd0, 5'd5));
    drain_outputs();
  endtask

  task automatic test_bad_row();
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h33, 2'd2, 5'd0));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'hFF, 2'd3, 5'd31));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h00, 2'd2, 5'd17));
    drain_outputs();
  endtask

  // Requests that produce nothing, mixed with ones that do.
  task automatic test_silent_requests();
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h55, 2'd0, 5'd16));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'hAA, 2'd1, 5'd31));
    send_req(make_req(CMD_UNUSED, 8'hFF, 2'd3, 5'd31));
    send_req(make_req(CMD_UNUSED, 8'h00, 2'd0, 5'd0));
    send_req(make_req(lcdseq_pkg::CMD_WRITE, 8'h21, 2'd1, 5'd7));
    send_req(make_req(CMD_UNUSED, 8'h12, 2'd1, 5'd3));
    send_req(make_req(lcdseq_pkg::CMD_CLEAR, 8'h9C, 2'd2, 5'd20));
    drain_outputs();
  endtask

  // Random traffic in bursts; mostly legal writes, with every other kind mixed in.
  task automatic test_random_traffic(int target);
    int               counted;
    int               burst;
    int               pick;
    lcdseq_pkg::req_t r;
    counted = 0;
    while (counted < target) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        pick        = $urandom_range(0, 99);
        r.char_code = 8'($urandom_range(0, 255));
        r.row       = 2'($urandom_range(0, 3));
        r.column    = 5'($urandom_range(0, 31));
        if (pick < 6) begin
          r.cmd = lcdseq_pkg::CMD_INIT;
        end else if (pick < 16) begin
          r.cmd = lcdseq_pkg::CMD_CLEAR;
        end else if (pick < 70) begin
          r.cmd    = lcdseq_pkg::CMD_WRITE;
          r.row    = 2'($urandom_range(0, 1));
          r.column = 5'($urandom_range(0, 15));
        end else if (pick < 82) begin
          r.cmd = lcdseq_pkg::CMD_WRITE;
          r.row = 2'($urandom_range(2, 3));
        end else if (pick < 92) begin
          r.cmd    = lcdseq_pkg::CMD_WRITE;
          r.row    = 2'($urandom_range(0, 1));
          r.column = 5'($urandom_range(16, 31));
        end else begin
          r.cmd = CMD_UNUSED;
        end
        send_req(r);
        counted++;
      end
      // About a third of the bursts run straight into the next one.
      if ($urandom_range(0, 2) != 0) begin
        pause_sender(int'($urandom_range(1, 20)));
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_outputs();
      end
    end
    drain_outputs();
  endtask

  // Compares each strobed transfer with the oldest expected one.
  always @(posedge clk) begin : check_xfers
    lcdseq_pkg::xfer_t want;
    if (!rst && strobe) begin
      if (pending_xfers.size() == 0) begin
        $error("transfer with none expected: nibble %0h rs %0b wait %0d last %0b",
               xfer.nibble, xfer.reg_select, xfer.wait_us, xfer.last);
        error_count++;
      end else begin
        want = pending_xfers.pop_front();
        xfers_checked++;
        if (xfer.nibble !== want.nibble) begin
          $error("nibble: expected %0h, got %0h", want.nibble, xfer.nibble);
          error_count++;
        end
        if (xfer.reg_select !== want.reg_select) begin
          $error("reg_select: expected %0b, got %0b", want.reg_select, xfer.reg_select);
          error_count++;
        end
        if (xfer.wait_us !== want.wait_us) begin
          $error("wait_us: expected %0d, got %0d", want.wait_us, xfer.wait_us);
          error_count++;
        end
        if (xfer.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, xfer.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles where no transaction moves in either direction.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_init_and_clear();
    test_write_corners();
    test_bad_row();
    test_silent_requests();
    test_random_traffic(290);

    pause_sender(10);
    $display("Covered %0d requests (init, clear, writes, bad row, bad column, unused kind)",
             requests_sent);
    $display("and checked %0d nibble transfers against the expanded sequences.",
             xfers_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/lcdseq_pkg.sv
sv/lcdseq_front.sv
sv/lcdseq_queue.sv
sv/lcdseq_back.sv
sv/char_lcd_nibble_sequencer.sv
verif/tb.sv
